FILE: rtl/newton_square_root_top_macros.svh
// Assertion macros for the Newton square root block.
`ifndef NEWTON_SQUARE_ROOT_TOP_MACROS_SVH
`define NEWTON_SQUARE_ROOT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsr assertion failed");
`define NSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsr assertion failed");
`else
`define NSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/nsr_pkg.sv
// Shared types and constants for the Newton square root block.
`timescale 1ns / 1ps
`default_nettype none
package nsr_pkg;
    localparam int ROOT_W        = 64;
    localparam int STEPS_W       = 7;
    localparam int TOL_W         = 33;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 33;
    localparam int FRAC_BITS_DEF = 32;

    localparam logic [STEPS_W-1:0]   MAX_ITER    = 7'd64;
    localparam logic [TOL_W-1:0]     TOL_RESET   = 33'd4295;
    localparam logic [STEPS_W-1:0]   LIMIT_RESET = 7'd64;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_UPD,
        S_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage
`default_nettype wire

FILE: rtl/nsr_if.sv
// Handshake channel interfaces: radicand in, result out, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface nsr_in_if;
    logic                       valid;
    logic                       ready;
    logic [nsr_pkg::ROOT_W-1:0] radicand;
    modport source (output valid, output radicand, input ready);
    modport sink (input valid, input radicand, output ready);
endinterface

interface nsr_out_if;
    logic                        valid;
    logic                        ready;
    logic [nsr_pkg::ROOT_W-1:0]  root;
    logic [nsr_pkg::STEPS_W-1:0] steps_taken;
    logic                        not_converged;
    modport source (output valid, output root, output steps_taken, output not_converged,
                    input ready);
    modport sink (input valid, input root, input steps_taken, input not_converged,
                  output ready);
endinterface

interface nsr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nsr_pkg::CFG_IDX_W-1:0]  index;
    logic [nsr_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/newton_square_root_top.sv
// Newton square root top level: register file, step sequencer, result register.
//
//  channel  | dir | handshake       | payload
//  i_in     | in  | valid / ready   | radicand[63:0]
//  o_out    | out | valid / ready   | root[63:0], steps_taken[6:0], not_converged
//  i_cfg    | in  | valid / ready   | index[7:0], data[32:0]
//
// Each Newton step runs the start, divide, update and check states; divide waits for the bit-serial divider.
// An item takes at most 64 steps; a zero radicand skips them and goes straight to done.
// Reset clears the sequencer and loads tolerance 4295 and iteration limit 64.
// Ready is high only while the sequencer is idle; a held result does not block input.
// Register writes are taken in any cycle out of reset.
`timescale 1ns / 1ps
`default_nettype none
`include "newton_square_root_top_macros.svh"
module newton_square_root_top #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    nsr_in_if.sink   i_in,
    nsr_out_if.source o_out,
    nsr_cfg_if.sink  i_cfg
);
    import nsr_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [TOL_W-1:0]   r_tol;
    logic [STEPS_W-1:0] r_lim_reg;
    logic [STEPS_W-1:0] r_limit;
    logic [ROOT_W-1:0]  r_rad;
    logic [ROOT_W-1:0]  r_root;
    logic [ROOT_W-1:0]  r_prev;
    logic [STEPS_W-1:0] r_steps;
    logic               r_nc;

    logic               r_out_valid;
    logic [ROOT_W-1:0]  r_out_root;
    logic [STEPS_W-1:0] r_out_steps;
    logic               r_out_nc;

    t_div_ctrl         div_ctrl;
    t_div_stat         div_stat;
    logic [ROOT_W-1:0] div_quo;

    logic               in_fire;
    logic               out_free;
    logic [STEPS_W-1:0] lim_clamped;
    logic [ROOT_W-1:0]  n_diff;
    logic               n_met;

    nsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .i_num   (r_rad),
        .i_den   (r_root),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign i_cfg.ready = i_rst_n;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        if (r_lim_reg == '0) begin
            lim_clamped = STEPS_W'(1);
        end else if (r_lim_reg > MAX_ITER) begin
            lim_clamped = MAX_ITER;
        end else begin
            lim_clamped = r_lim_reg;
        end
    end

    always_comb begin
        n_diff = (r_prev > r_root) ? (r_prev - r_root) : (r_root - r_prev);
        n_met  = (n_diff <= {{(ROOT_W-TOL_W){1'b0}}, r_tol});
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in.radicand == '0) ? S_DONE : S_START;
                end
            end
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_CHK;
            S_CHK: begin
                if (n_met || (r_steps == r_limit)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_START;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready     = 1'b0;
        div_ctrl.start = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready     = i_rst_n;
            S_START: div_ctrl.start = 1'b1;
            default: begin
                i_in.ready     = 1'b0;
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= TOL_RESET;
            r_lim_reg   <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_TOLERANCE) begin
                    r_tol <= i_cfg.data;
                end else if (i_cfg.index == REG_ITER_LIMIT) begin
                    r_lim_reg <= i_cfg.data[STEPS_W-1:0];
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_rad   <= i_in.radicand;
                    r_limit <= lim_clamped;
                    r_steps <= '0;
                    r_nc    <= 1'b0;
                    r_root  <= (i_in.radicand == '0) ? '0 : (ROOT_W'(1) << FRAC_BITS);
                end
            end
            S_UPD: begin
                r_prev  <= r_root;
                r_root  <= (r_root >> 1) + (div_quo >> 1)
                           + {{(ROOT_W-1){1'b0}}, r_root[0] & div_quo[0]};
                r_steps <= r_steps + 1'b1;
            end
            S_CHK: begin
                r_nc <= !n_met;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_root  <= r_root;
                    r_out_steps <= r_steps;
                    r_out_nc    <= r_nc;
                end
            end
            default: begin
                r_rad <= r_rad;
            end
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.root          = r_out_root;
    assign o_out.steps_taken   = r_out_steps;
    assign o_out.not_converged = r_out_nc;

    `NSR_ASSERT_NXT(a_nonzero_starts, i_clk, i_rst_n, in_fire && (i_in.radicand != '0), r_state == S_START)
    `NSR_ASSERT_IMP(a_div_busy, i_clk, i_rst_n, (r_state == S_DIV) && !div_stat.done, div_stat.busy)
    `NSR_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, div_stat.done, r_state == S_DIV)
    `NSR_ASSERT_IMP(a_steps_bound, i_clk, i_rst_n, r_state == S_CHK, (r_steps != '0) && (r_steps <= r_limit))
    `NSR_ASSERT_NXT(a_upd_to_chk, i_clk, i_rst_n, r_state == S_UPD, r_state == S_CHK)
endmodule
`default_nettype wire

FILE: rtl/nsr_div.sv
// Bit-serial restoring divider: saturated floor((n * 2^F) / d), one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module nsr_div #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire nsr_pkg::t_div_ctrl         i_ctrl,
    input  wire logic [nsr_pkg::ROOT_W-1:0] i_num,
    input  wire logic [nsr_pkg::ROOT_W-1:0] i_den,
    output nsr_pkg::t_div_stat              o_stat,
    output logic [nsr_pkg::ROOT_W-1:0]      o_quo
);
    import nsr_pkg::*;

    localparam int DVD_W = ROOT_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [ROOT_W-1:0] r_dvd;
    logic [ROOT_W-1:0] r_den;
    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_quo;
    logic              r_over;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W:0] n_trial;
    logic [ROOT_W:0] n_diff;
    logic            n_qb;

    always_comb begin
        n_trial = {r_rem, r_dvd[ROOT_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_qb    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_dvd  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ROOT_W-2:0], 1'b0};
            r_rem <= n_qb ? n_diff[ROOT_W-1:0] : n_trial[ROOT_W-1:0];
            r_quo <= {r_quo[ROOT_W-2:0], n_qb};
            if (n_qb && (r_cnt > CNT_W'(ROOT_W))) begin
                r_over <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_over ? {ROOT_W{1'b1}} : r_quo;
endmodule
`default_nettype wire

FILE: verif/newton_square_root_checker.sv
// Checker for the Newton square root block: predicts each root and compares the results.
`timescale 1ns / 1ps
module newton_square_root_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    nsr_in_if    i_in,
    nsr_out_if   i_res,
    nsr_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import nsr_pkg::*;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [STEPS_W-1:0] steps_taken;
        logic               not_converged;
    } root_result_t;

    root_result_t       expected_roots[$];
    root_result_t       want;
    logic [TOL_W-1:0]   tolerance  = TOL_RESET;
    logic [STEPS_W-1:0] iter_limit = LIMIT_RESET;
    int                 fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic root_result_t heron_sqrt(input logic [ROOT_W-1:0] radicand,
                                                input logic [TOL_W-1:0] tol,
                                                input logic [STEPS_W-1:0] limit_reg);
        root_result_t         res;
        logic [2*ROOT_W-1:0]  dividend;
        logic [2*ROOT_W-1:0]  quotient;
        logic [ROOT_W-1:0]    guess;
        logic [ROOT_W-1:0]    quot;
        logic [ROOT_W-1:0]    next_guess;
        logic [ROOT_W-1:0]    diff;
        int                   limit;
        int                   steps;
        res   = '0;
        steps = 0;
        if (limit_reg == 0) begin
            limit = 1;
        end else if (limit_reg > MAX_ITER) begin
            limit = int'(MAX_ITER);
        end else begin
            limit = int'(limit_reg);
        end
        if (radicand == 0) begin
            return res;
        end
        res.not_converged = 1'b1;
        dividend = {{ROOT_W{1'b0}}, radicand} << FRAC_BITS_DEF;
        guess    = ROOT_W'(1) << FRAC_BITS_DEF;
        while (steps < limit) begin
            if (guess == 0) begin
                quot = '1;
            end else begin
                quotient = dividend / {{ROOT_W{1'b0}}, guess};
                quot = (quotient[2*ROOT_W-1:ROOT_W] != 0) ? '1 : quotient[ROOT_W-1:0];
            end
            next_guess = (guess >> 1) + (quot >> 1) + ROOT_W'(guess[0] & quot[0]);
            diff  = (guess > next_guess) ? guess - next_guess : next_guess - guess;
            guess = next_guess;
            steps++;
            if (diff <= {{(ROOT_W-TOL_W){1'b0}}, tol}) begin
                res.not_converged = 1'b0;
                break;
            end
        end
        res.root        = guess;
        res.steps_taken = STEPS_W'(steps);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_roots.delete();
            tolerance  = TOL_RESET;
            iter_limit = LIMIT_RESET;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_roots.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with none expected: root=%h steps=%0d nc=%b",
                                 $realtime, i_res.root, i_res.steps_taken, i_res.not_converged);
                    end
                end else begin
                    want = expected_roots.pop_front();
                    if (i_res.root !== want.root || i_res.steps_taken !== want.steps_taken ||
                        i_res.not_converged !== want.not_converged) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: expected root=%h steps=%0d nc=%b",
                                     $realtime, want.root, want.steps_taken,
                                     want.not_converged);
                            $display("%0t:           actual   root=%h steps=%0d nc=%b",
                                     $realtime, i_res.root, i_res.steps_taken,
                                     i_res.not_converged);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_roots.push_back(heron_sqrt(i_in.radicand, tolerance, iter_limit));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_TOLERANCE) begin
                    tolerance = i_cfg.data[TOL_W-1:0];
                end else if (i_cfg.index == REG_ITER_LIMIT) begin
                    iter_limit = i_cfg.data[STEPS_W-1:0];
                end
            end
        end
        o_pending    <= expected_roots.size();
        o_fail_count <= fail_count;
    end
endmodule

FILE: verif/newton_square_root_top_test.sv
// Testbench top for the Newton square root block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module newton_square_root_top_test;
    import nsr_pkg::*;

    logic i_clk;
    logic i_rst_n;
    bit   idling_on;
    int   fail_count;
    int   pending;

    nsr_in_if  in_ch ();
    nsr_out_if out_ch ();
    nsr_cfg_if cfg_ch ();

    newton_square_root_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    newton_square_root_checker root_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stall bursts while idling is on
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_radicand(input logic [ROOT_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.radicand <= value;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [ROOT_W-1:0] random_radicand();
        logic [ROOT_W-1:0] k;
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return {$urandom, $urandom};
            3: begin
                k = ROOT_W'($urandom_range(0, 65535));
                return (k * k) << FRAC_BITS_DEF;
            end
            4: return (ROOT_W'(1) << FRAC_BITS_DEF) + ROOT_W'($urandom_range(0, 65535))
                      - ROOT_W'(32768);
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    logic [ROOT_W-1:0] directed_radicands [12] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0001_0000_0000, 64'h0000_0004_0000_0000, 64'h8000_0000_0000_0000,
        64'h0000_0000_FFFF_FFFF, 64'h0000_0002_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555, 64'h0000_0000_0000_0002, 64'hFFFF_FFFF_0000_0000
    };

    initial begin
        logic [TOL_W-1:0]   tol;
        logic [STEPS_W-1:0] limit_val;
        idling_on = 1'b1;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.radicand <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_TOLERANCE;
        cfg_ch.data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_radicands[i]) send_radicand(directed_radicands[i]);

        // limit of zero behaves as one
        write_register(REG_ITER_LIMIT, '0);
        send_radicand(64'hFFFF_FFFF_FFFF_FFFF);
        send_radicand(random_radicand());

        // limit above the cap with zero tolerance
        write_register(REG_TOLERANCE, '0);
        write_register(REG_ITER_LIMIT, CFG_DATA_W'(7'h7F));
        send_radicand(64'hFFFF_FFFF_FFFF_FFFF);
        send_radicand(64'h0000_0000_0000_0001);
        send_radicand({$urandom, $urandom});

        // widest tolerance, single step
        write_register(REG_TOLERANCE, '1);
        write_register(REG_ITER_LIMIT, CFG_DATA_W'(1));
        send_radicand(64'h0000_0003_0000_0000);
        send_radicand(64'hFFFF_FFFF_FFFF_FFFF);

        // top bit of the tolerance alone, upper data bits set on the limit write
        write_register(REG_TOLERANCE, CFG_DATA_W'(33'h1_0000_0000));
        write_register(REG_ITER_LIMIT, {26'h3FF_FFFF, MAX_ITER});
        send_radicand(64'h0000_0010_0000_0000);
        send_radicand(random_radicand());

        write_register(REG_ITER_LIMIT + CFG_IDX_W'(1) + CFG_IDX_W'($urandom_range(0, 253)),
                       {1'($urandom_range(0, 1)), $urandom});
        send_radicand(random_radicand());

        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 3))
                0: tol = TOL_W'($urandom_range(0, 255));
                1: tol = TOL_W'($urandom >> $urandom_range(0, 31));
                2: tol = {1'($urandom_range(0, 1)), $urandom};
                default: tol = '0;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                limit_val = STEPS_W'($urandom_range(0, 127));
            end else begin
                limit_val = STEPS_W'($urandom_range(1, 24));
            end
            if (tol == 0 && limit_val > 24) begin
                limit_val = STEPS_W'(24);
            end
            write_register(REG_TOLERANCE, CFG_DATA_W'(tol));
            write_register(REG_ITER_LIMIT, {26'($urandom), limit_val});
            for (int n = 0; n < 36; n++) begin
                if ($urandom_range(0, 24) == 0) begin
                    wait_drained();
                end
                send_radicand(random_radicand());
            end
        end

        write_register(REG_TOLERANCE, CFG_DATA_W'(TOL_RESET));
        write_register(REG_ITER_LIMIT, CFG_DATA_W'(LIMIT_RESET));
        idling_on = 1'b0;
        for (int n = 0; n < 16; n++) send_radicand(random_radicand());

        wait_drained();
        repeat (7000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: newton_square_root_top.f
+incdir+rtl
rtl/nsr_pkg.sv
rtl/nsr_if.sv
rtl/nsr_div.sv
rtl/newton_square_root_top.sv
verif/newton_square_root_checker.sv
verif/newton_square_root_top_test.sv
